@@ hdl/multi_user_code_lock_fsm_unit_assert.svh @@
// ----------------------------------------------------------------------------
// multi_user_code_lock_fsm_unit_assert.svh
// assertion macros for the code lock checker
// ----------------------------------------------------------------------------
`ifndef MULTI_USER_CODE_LOCK_FSM_UNIT_ASSERT_SVH
`define MULTI_USER_CODE_LOCK_FSM_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MCL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define MCL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/mcl_pkg.sv @@
// ----------------------------------------------------------------------------
// mcl_pkg
// constants, key codes and default user codes of the code lock
// ----------------------------------------------------------------------------
package mcl_pkg;

	localparam int NUM_USERS   = 5;
	localparam int CODE_DIGITS = 4;

	localparam int CODE_W     = 4 * CODE_DIGITS;
	localparam int CNT_W      = $clog2(CODE_DIGITS + 1);
	localparam int USER_W     = $clog2(NUM_USERS + 1);
	localparam int USER_IDX_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int KEY_W      = 4;
	localparam int NUM_KEYS   = 13;
	localparam int NUM_DEFS   = 9;

	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [CODE_W-1:0]     code_t;
	typedef logic [USER_IDX_W-1:0] user_idx_t;

	localparam key_t K_DIGIT_MAX = 4'd9;
	localparam key_t K_POWER     = 4'd10;
	localparam key_t K_STAR      = 4'd11;
	localparam key_t K_HASH      = 4'd12;
	localparam key_t K_NONE      = 4'd15;

	localparam logic [2:0] MODE_LOCKED  = 3'd0;
	localparam logic [2:0] MODE_SELECT  = 3'd1;
	localparam logic [2:0] MODE_CODE    = 3'd2;
	localparam logic [2:0] MODE_MENU    = 3'd3;
	localparam logic [2:0] MODE_NEWCODE = 3'd4;
	localparam logic [2:0] MODE_ENTERED = 3'd5;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_GRANT   = 2'd1;
	localparam logic [1:0] EV_DENY    = 2'd2;
	localparam logic [1:0] EV_CHANGED = 2'd3;

	localparam logic [31:0] KEY_CODES [NUM_KEYS] = '{
		32'h01FEE01F, 32'h01FE50AF, 32'h01FED827, 32'h01FEF807, 32'h01FE30CF,
		32'h01FEB04F, 32'h01FE708F, 32'h01FE00FF, 32'h01FEF00F, 32'h01FE9867,
		32'h01FE48B7, 32'h01FE58A7, 32'h01FE7887
	};

	localparam logic [31:0] DEFAULT_CODES [NUM_DEFS] = '{
		32'h1234, 32'h2345, 32'h3456, 32'h1111, 32'h2222,
		32'h0, 32'h0, 32'h0, 32'h0
	};

	typedef struct packed {
		logic      en;
		user_idx_t idx;
		code_t     data;
	} store_wr_t;

endpackage

@@ hdl/mcl_key_dec.sv @@
// ----------------------------------------------------------------------------
// mcl_key_dec
// maps a raw remote code to a key number, K_NONE when unknown
// ----------------------------------------------------------------------------
module mcl_key_dec (
	input  logic [31:0]  ir_code,
	output mcl_pkg::key_t key
);
	import mcl_pkg::*;

	always_comb begin
		key = K_NONE;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (ir_code == KEY_CODES[i]) begin
				key = KEY_W'(i);
			end
		end
	end

endmodule

@@ hdl/mcl_code_store.sv @@
// ----------------------------------------------------------------------------
// mcl_code_store
// per-user code registers, reset to the default codes
// ----------------------------------------------------------------------------
module mcl_code_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mcl_pkg::store_wr_t   wr,
	input  mcl_pkg::user_idx_t   rd_idx,
	output mcl_pkg::code_t       rd_data
);
	import mcl_pkg::*;

	code_t codes_q [NUM_USERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_USERS; i++) begin
				codes_q[i] <= DEFAULT_CODES[i][CODE_W-1:0];
			end
		end else if (wr.en && (int'(wr.idx) < NUM_USERS)) begin
			codes_q[wr.idx] <= wr.data;
		end
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < NUM_USERS; i++) begin
			if (int'(rd_idx) == i) begin
				rd_data = codes_q[i];
			end
		end
	end

endmodule

@@ hdl/multi_user_code_lock_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// multi_user_code_lock_fsm_unit
// multi-user code lock: remote key decode, user select, code check and change
//
//   channel  dir  handshake           word
//   ir       in   ir_valid/ir_stall   ir_code
//   res      out  res_valid/res_stall mode, event_res, digits_entered,
//                                     selected_user, key_known
//
// one word per cycle while ir_stall is low; a result is registered after its word is taken
// (input register, then lock state update into the result register)
// ir_stall is high while a result waits with res_stall high
// arst_n puts the lock in locked mode and reloads the default user codes
// ----------------------------------------------------------------------------
module multi_user_code_lock_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ir_valid,
	output logic        ir_stall,
	input  logic [31:0] ir_code,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  mode,
	output logic [1:0]  event_res,
	output logic [2:0]  digits_entered,
	output logic [2:0]  selected_user,
	output logic        key_known
);
	import mcl_pkg::*;

	typedef enum logic [2:0] {
		ST_LOCKED  = MODE_LOCKED,
		ST_SELECT  = MODE_SELECT,
		ST_CODE    = MODE_CODE,
		ST_MENU    = MODE_MENU,
		ST_NEWCODE = MODE_NEWCODE,
		ST_ENTERED = MODE_ENTERED
	} st_t;

	st_t               st_q, st_nxt;
	logic [USER_W-1:0] user_q, user_nxt;
	code_t             digits_q, digits_nxt;
	logic [CNT_W-1:0]  count_q, count_nxt;
	logic [1:0]        ev_nxt;

	logic        valid_s1;
	logic [31:0] code_s1;
	logic        valid_s2;
	logic [2:0]  mode_s2;
	logic [1:0]  event_s2;
	logic [2:0]  digits_s2;
	logic [2:0]  user_s2;
	logic        known_s2;

	logic      adv;
	key_t      key;
	code_t     stored;
	store_wr_t wr;
	logic      user_ok;
	logic      is_digit;
	logic      full;
	code_t     shifted;

	assign adv      = !(valid_s2 && res_stall);
	assign ir_stall = !adv;

	mcl_key_dec u_key_dec (
		.ir_code (code_s1),
		.key     (key)
	);

	mcl_code_store u_code_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (USER_IDX_W'(user_q - 1'b1)),
		.rd_data (stored)
	);

	assign user_ok  = (user_q != '0) && (int'(user_q) <= NUM_USERS);
	assign is_digit = (key <= K_DIGIT_MAX);
	assign full     = (int'(count_q) == CODE_DIGITS);
	assign shifted  = CODE_W'({digits_q, key});

	always_comb begin
		st_nxt     = st_q;
		user_nxt   = user_q;
		digits_nxt = digits_q;
		count_nxt  = count_q;
		ev_nxt     = EV_NONE;
		wr.en      = 1'b0;
		wr.idx     = USER_IDX_W'(user_q - 1'b1);
		wr.data    = digits_q;
		if (key != K_NONE) begin
			unique case (st_q)
				ST_LOCKED: begin
					if (key == K_POWER) begin
						st_nxt   = ST_SELECT;
						user_nxt = '0;
					end
				end
				ST_SELECT: begin
					if (is_digit && key != '0) begin
						if (int'(key) <= NUM_USERS) begin
							user_nxt = USER_W'(key);
						end
					end else if (key == K_HASH) begin
						if (user_ok) begin
							st_nxt     = ST_CODE;
							digits_nxt = '0;
							count_nxt  = '0;
						end
					end else if (key == K_STAR) begin
						st_nxt     = ST_LOCKED;
						user_nxt   = '0;
						digits_nxt = '0;
						count_nxt  = '0;
					end
				end
				ST_CODE, ST_NEWCODE: begin
					if (is_digit) begin
						if (!full) begin
							digits_nxt = shifted;
							count_nxt  = count_q + 1'b1;
						end
					end else if (key == K_HASH) begin
						if (full) begin
							digits_nxt = '0;
							count_nxt  = '0;
							st_nxt     = ST_SELECT;
							if (st_q == ST_NEWCODE) begin
								wr.en  = user_ok;
								ev_nxt = EV_CHANGED;
							end else if (user_ok && digits_q == stored) begin
								st_nxt = ST_MENU;
								ev_nxt = EV_GRANT;
							end else begin
								ev_nxt = EV_DENY;
							end
						end
					end else if (key == K_STAR) begin
						st_nxt     = (st_q == ST_NEWCODE) ? ST_MENU : ST_SELECT;
						digits_nxt = '0;
						count_nxt  = '0;
					end
				end
				ST_MENU: begin
					if (key == KEY_W'(1)) begin
						st_nxt     = ST_NEWCODE;
						digits_nxt = '0;
						count_nxt  = '0;
					end else if (key == KEY_W'(2)) begin
						st_nxt = ST_ENTERED;
					end else if (key == K_STAR) begin
						st_nxt     = ST_LOCKED;
						user_nxt   = '0;
						digits_nxt = '0;
						count_nxt  = '0;
					end
				end
				ST_ENTERED: begin
					if (key == K_STAR) begin
						st_nxt     = ST_LOCKED;
						user_nxt   = '0;
						digits_nxt = '0;
						count_nxt  = '0;
					end
				end
				default: begin
					st_nxt     = ST_LOCKED;
					user_nxt   = '0;
					digits_nxt = '0;
					count_nxt  = '0;
				end
			endcase
		end
		if (!(valid_s1 && adv)) begin
			wr.en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_LOCKED;
			user_q    <= '0;
			digits_q  <= '0;
			count_q   <= '0;
			valid_s1  <= 1'b0;
			code_s1   <= '0;
			valid_s2  <= 1'b0;
			mode_s2   <= MODE_LOCKED;
			event_s2  <= EV_NONE;
			digits_s2 <= '0;
			user_s2   <= '0;
			known_s2  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= ir_valid;
			code_s1  <= ir_code;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				st_q      <= st_nxt;
				user_q    <= user_nxt;
				digits_q  <= digits_nxt;
				count_q   <= count_nxt;
				mode_s2   <= st_nxt;
				event_s2  <= ev_nxt;
				digits_s2 <= (st_nxt == ST_CODE || st_nxt == ST_NEWCODE) ?
					3'(count_nxt) : 3'd0;
				user_s2   <= 3'(user_nxt);
				known_s2  <= (key != K_NONE);
			end
		end
	end

	assign res_valid      = valid_s2;
	assign mode           = mode_s2;
	assign event_res      = event_s2;
	assign digits_entered = digits_s2;
	assign selected_user  = user_s2;
	assign key_known      = known_s2;

endmodule

@@ hdl/mcl_checker.sv @@
// ----------------------------------------------------------------------------
// mcl_checker
// port-level checks of the code lock results, bound to the top level
// ----------------------------------------------------------------------------
`include "multi_user_code_lock_fsm_unit_assert.svh"

module mcl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [2:0] mode,
	input logic [1:0] event_res,
	input logic [2:0] digits_entered,
	input logic [2:0] selected_user,
	input logic       key_known
);
	import mcl_pkg::*;

	`MCL_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable({mode, event_res, digits_entered, selected_user, key_known}), "result word changed while stalled")
	`MCL_ASSERT_NOW(a_grant_menu, clk, arst_n, res_valid && event_res == EV_GRANT, mode == MODE_MENU, "access granted outside menu")
	`MCL_ASSERT_NOW(a_back_select, clk, arst_n, res_valid && (event_res == EV_DENY || event_res == EV_CHANGED), mode == MODE_SELECT, "deny or change not back in user select")
	`MCL_ASSERT_NOW(a_locked_clear, clk, arst_n, res_valid && mode == MODE_LOCKED, selected_user == 3'd0 && digits_entered == 3'd0, "locked with user or digits")
	`MCL_ASSERT_NOW(a_unknown_quiet, clk, arst_n, res_valid && !key_known, event_res == EV_NONE, "event raised by unknown code")

endmodule

bind multi_user_code_lock_fsm_unit mcl_checker u_mcl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.mode           (mode),
	.event_res      (event_res),
	.digits_entered (digits_entered),
	.selected_user  (selected_user),
	.key_known      (key_known)
);
